>>> rtl/irpt_pkg.sv
// shared types, register codes and helpers for the ir pulse train transmitter
// used by irpt_mem, irpt_seq and ir_pulse_train_transmitter
package irpt_pkg;

    localparam int IRPT_PATTERN_DEPTH = 64;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    localparam logic [2:0] CFG_PATTERN_LENGTH = 3'd0;
    localparam logic [2:0] CFG_REPEAT_TOTAL   = 3'd1;
    localparam logic [2:0] CFG_GAP_DURATION   = 3'd2;
    localparam logic [2:0] CFG_CARRIER_PERIOD = 3'd3;
    localparam logic [2:0] CFG_TICK_PRESCALE  = 3'd4;

    localparam logic [6:0]  RST_PATTERN_LENGTH = 7'd1;
    localparam logic [15:0] RST_REPEAT_TOTAL   = 16'd1;
    localparam logic [15:0] RST_GAP_DURATION   = 16'd0;
    localparam logic [15:0] RST_CARRIER_PERIOD = 16'd3000;
    localparam logic [7:0]  RST_TICK_PRESCALE  = 8'd83;

    typedef struct packed {
        logic [6:0]  pattern_length;
        logic [15:0] repeat_total;
        logic [15:0] gap_duration;
        logic [15:0] carrier_period;
        logic [7:0]  tick_prescale;
    } cfg_t;

    typedef struct packed {
        logic ir_out;
        logic mark_active;
        logic busy_res;
        logic done_res;
    } res_t;

    function automatic logic [15:0] at_least_one(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

endpackage

>>> rtl/irpt_mem.sv
// pattern duration memory: one write port, one read port with registered data
// depends on irpt_pkg
module irpt_mem
    import irpt_pkg::*;
#(
    parameter int PATTERN_DEPTH = IRPT_PATTERN_DEPTH,
    parameter int AW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data
);

    logic [15:0] mem [PATTERN_DEPTH];
    logic [15:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/irpt_seq.sv
// playback sequencer: prescaler, carrier counter, entry pointer, repeat and gap control
// depends on irpt_pkg; reads durations from irpt_mem's registered read port after a load
module irpt_seq
    import irpt_pkg::*;
#(
    parameter int PATTERN_DEPTH = IRPT_PATTERN_DEPTH,
    parameter int AW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  logic [1:0]    req_type,
    input  cfg_t          cfg,
    input  logic [15:0]   rd_data,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    output res_t          res
);

    localparam int CW = ((AW > 7) ? AW : 7) + 1;

    logic [AW-1:0] ptr_reg, ptr_next;
    logic [15:0]   rep_reg, rep_next;
    logic [15:0]   dur_reg, dur_next;
    logic          pend_reg, pend_next;
    logic [7:0]    presc_reg, presc_next;
    logic [15:0]   cc_reg, cc_next;
    logic          gate_reg, gate_next;
    logic          send_reg, send_next;
    logic          gap_reg, gap_next;

    logic [15:0]   dur_cur;
    logic [15:0]   dur_dec;
    logic [15:0]   per_eff;
    logic [15:0]   cc_inc;
    logic [CW-1:0] len_raw;
    logic [CW-1:0] len_eff;
    logic [CW-1:0] ptr_plus;
    logic          load;
    logic [AW-1:0] load_idx;
    logic          done;

    assign dur_cur  = pend_reg ? at_least_one(rd_data) : dur_reg;
    assign per_eff  = (cfg.carrier_period < 16'd2) ? 16'd2 : cfg.carrier_period;
    assign cc_inc   = cc_reg + 16'd1;
    assign dur_dec  = (dur_cur != 16'd0) ? (dur_cur - 16'd1) : dur_cur;
    assign len_raw  = CW'(cfg.pattern_length);
    assign ptr_plus = CW'(ptr_reg) + CW'(1);

    always_comb begin
        if (len_raw == '0) begin
            len_eff = CW'(1);
        end else if (len_raw > CW'(PATTERN_DEPTH)) begin
            len_eff = CW'(PATTERN_DEPTH);
        end else begin
            len_eff = len_raw;
        end
    end

    always_comb begin
        ptr_next   = ptr_reg;
        rep_next   = rep_reg;
        dur_next   = dur_reg;
        pend_next  = pend_reg;
        presc_next = presc_reg;
        cc_next    = cc_reg;
        gate_next  = gate_reg;
        send_next  = send_reg;
        gap_next   = gap_reg;
        load       = 1'b0;
        load_idx   = '0;
        done       = 1'b0;
        if (accept) begin
            case (req_type)
                REQ_TICK: begin
                    cc_next = (cc_inc >= per_eff) ? 16'd0 : cc_inc;
                    if (send_reg) begin
                        if (presc_reg >= cfg.tick_prescale) begin
                            presc_next = 8'd0;
                            dur_next   = dur_dec;
                            pend_next  = 1'b0;
                            if (dur_dec == 16'd0) begin
                                if (gap_reg) begin
                                    gap_next = 1'b0;
                                    load     = 1'b1;
                                end else if (ptr_plus < len_eff) begin
                                    load     = 1'b1;
                                    load_idx = ptr_plus[AW-1:0];
                                end else begin
                                    gate_next = 1'b0;
                                    rep_next  = rep_reg - 16'd1;
                                    ptr_next  = '0;
                                    if (rep_reg == 16'd1) begin
                                        send_next = 1'b0;
                                        dur_next  = 16'd0;
                                        done      = 1'b1;
                                    end else begin
                                        gap_next = 1'b1;
                                        dur_next = at_least_one(cfg.gap_duration);
                                    end
                                end
                            end
                        end else begin
                            presc_next = presc_reg + 8'd1;
                        end
                    end
                end
                REQ_START: begin
                    send_next  = 1'b1;
                    gap_next   = 1'b0;
                    rep_next   = at_least_one(cfg.repeat_total);
                    presc_next = 8'd0;
                    load       = 1'b1;
                end
                default: ;
            endcase
            if (load) begin
                ptr_next  = load_idx;
                gate_next = ~load_idx[0];
                pend_next = 1'b1;
            end
        end
    end

    assign rd_en   = load;
    assign rd_addr = load_idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg   <= '0;
            rep_reg   <= '0;
            dur_reg   <= '0;
            pend_reg  <= 1'b0;
            presc_reg <= '0;
            cc_reg    <= '0;
            gate_reg  <= 1'b0;
            send_reg  <= 1'b0;
            gap_reg   <= 1'b0;
        end else begin
            ptr_reg   <= ptr_next;
            rep_reg   <= rep_next;
            dur_reg   <= dur_next;
            pend_reg  <= pend_next;
            presc_reg <= presc_next;
            cc_reg    <= cc_next;
            gate_reg  <= gate_next;
            send_reg  <= send_next;
            gap_reg   <= gap_next;
        end
    end

    always_comb begin
        res.mark_active = send_next & gate_next;
        res.ir_out      = res.mark_active & (cc_next < (per_eff >> 1));
        res.busy_res    = send_next;
        res.done_res    = done;
    end

endmodule

>>> rtl/ir_pulse_train_transmitter.sv
// ir mark/space pulse train transmitter top level
// result: registered in the output register on each input transfer
// throughput: one item per cycle unless the result register stalls; a loaded duration
//   is read from the pattern memory in the load cycle and used from the next item on
// reset: control and configuration cleared to defaults, pattern memory not cleared
// depends on irpt_pkg, irpt_mem, irpt_seq
module ir_pulse_train_transmitter
    import irpt_pkg::*;
#(
    parameter int PATTERN_DEPTH = IRPT_PATTERN_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [5:0]  s_entry_index,
    input  logic [15:0] s_entry_duration,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ir_out,
    output logic        m_mark_active,
    output logic        m_busy_res,
    output logic        m_done_res,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int IW = ((AW > 6) ? AW : 6) + 1;

    cfg_t          cfg_reg;
    res_t          res;
    res_t          res_reg;
    logic          m_valid_reg;
    logic          s_accept;
    logic          mem_wr_en;
    logic [IW-1:0] wr_idx;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [15:0]   rd_data;

    assign s_ready   = ~m_valid_reg | m_ready;
    assign s_accept  = s_valid & s_ready;
    assign cfg_ready = 1'b1;

    assign wr_idx    = IW'(s_entry_index);
    assign mem_wr_en = s_accept && (s_req_type == REQ_WRITE) && (wr_idx < IW'(PATTERN_DEPTH));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern_length <= RST_PATTERN_LENGTH;
            cfg_reg.repeat_total   <= RST_REPEAT_TOTAL;
            cfg_reg.gap_duration   <= RST_GAP_DURATION;
            cfg_reg.carrier_period <= RST_CARRIER_PERIOD;
            cfg_reg.tick_prescale  <= RST_TICK_PRESCALE;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_PATTERN_LENGTH: cfg_reg.pattern_length <= cfg_data[6:0];
                CFG_REPEAT_TOTAL:   cfg_reg.repeat_total   <= cfg_data;
                CFG_GAP_DURATION:   cfg_reg.gap_duration   <= cfg_data;
                CFG_CARRIER_PERIOD: cfg_reg.carrier_period <= cfg_data;
                CFG_TICK_PRESCALE:  cfg_reg.tick_prescale  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    irpt_mem #(
        .PATTERN_DEPTH (PATTERN_DEPTH),
        .AW            (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (wr_idx[AW-1:0]),
        .wr_data (s_entry_duration),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    irpt_seq #(
        .PATTERN_DEPTH (PATTERN_DEPTH),
        .AW            (AW)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (s_accept),
        .req_type (s_req_type),
        .cfg      (cfg_reg),
        .rd_data  (rd_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .res      (res)
    );

    // result register, refilled on every input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            res_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_ir_out      = res_reg.ir_out;
    assign m_mark_active = res_reg.mark_active;
    assign m_busy_res    = res_reg.busy_res;
    assign m_done_res    = res_reg.done_res;

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> !m_busy_res)
        else $error("done result while still busy");

    a_ir_needs_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ir_out |-> m_mark_active)
        else $error("carrier out without mark");

    a_mark_needs_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_mark_active |-> m_busy_res)
        else $error("mark while not sending");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result register is stalled");

endmodule

>>> bench/ir_pulse_train_transmitter_test.sv
// self-checking bench for ir_pulse_train_transmitter: directed and random request traffic,
// every result transfer compared with an in-bench model of carrier, prescaler and player
// depends on irpt_pkg and the ir_pulse_train_transmitter rtl
module ir_pulse_train_transmitter_test;
    import irpt_pkg::*;

    localparam logic [1:0] REQ_IGNORED = 2'd3;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    logic        aclk             = 1'b0;
    logic        aresetn          = 1'b0;
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type       = REQ_TICK;
    logic [5:0]  s_entry_index    = 6'd0;
    logic [15:0] s_entry_duration = 16'd0;
    logic        m_valid;
    logic        m_ready          = 1'b0;
    logic        m_ir_out;
    logic        m_mark_active;
    logic        m_busy_res;
    logic        m_done_res;
    logic        cfg_valid        = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index        = CFG_PATTERN_LENGTH;
    logic [15:0] cfg_data         = 16'd0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asked    = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int fail_count    = 0;

    res_t awaited_outputs[$];

    logic [15:0] tone_store[IRPT_PATTERN_DEPTH];
    logic [6:0]  slot_ptr;
    logic [15:0] reps_left;
    logic [15:0] units_left;
    logic [7:0]  pre_cnt;
    logic [15:0] car_cnt;
    logic        gate;
    logic        playing;
    logic        gapping;
    cfg_t        shadow_cfg;

    ir_pulse_train_transmitter i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_entry_index    (s_entry_index),
        .s_entry_duration (s_entry_duration),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_ir_out         (m_ir_out),
        .m_mark_active    (m_mark_active),
        .m_busy_res       (m_busy_res),
        .m_done_res       (m_done_res),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #2 aclk = ~aclk;

    function automatic void clear_prediction();
        for (int i = 0; i < IRPT_PATTERN_DEPTH; i++) begin
            tone_store[i] = 16'd0;
        end
        slot_ptr   = 7'd0;
        reps_left  = 16'd0;
        units_left = 16'd0;
        pre_cnt    = 8'd0;
        car_cnt    = 16'd0;
        gate       = 1'b0;
        playing    = 1'b0;
        gapping    = 1'b0;
        shadow_cfg.pattern_length = RST_PATTERN_LENGTH;
        shadow_cfg.repeat_total   = RST_REPEAT_TOTAL;
        shadow_cfg.gap_duration   = RST_GAP_DURATION;
        shadow_cfg.carrier_period = RST_CARRIER_PERIOD;
        shadow_cfg.tick_prescale  = RST_TICK_PRESCALE;
    endfunction

    function automatic logic [15:0] live_period();
        return (shadow_cfg.carrier_period < 16'd2) ? 16'd2 : shadow_cfg.carrier_period;
    endfunction

    function automatic void load_slot(input logic [6:0] slot);
        slot_ptr   = slot;
        gate       = ~slot[0];
        units_left = (tone_store[slot[5:0]] == 16'd0) ? 16'd1 : tone_store[slot[5:0]];
    endfunction

    function automatic res_t predict_pulse_train(input logic [1:0] req, input logic [5:0] idx,
                                                 input logic [15:0] dur);
        res_t       r;
        logic       ended;
        logic       mark;
        logic [6:0] span;
        ended = 1'b0;
        span  = (shadow_cfg.pattern_length == 7'd0) ? 7'd1 : shadow_cfg.pattern_length;
        if (span > IRPT_PATTERN_DEPTH) span = 7'(IRPT_PATTERN_DEPTH);
        case (req)
            REQ_WRITE: tone_store[idx] = dur;
            REQ_START: begin
                playing   = 1'b1;
                gapping   = 1'b0;
                reps_left = (shadow_cfg.repeat_total == 16'd0) ? 16'd1
                                                               : shadow_cfg.repeat_total;
                pre_cnt   = 8'd0;
                load_slot(7'd0);
            end
            REQ_TICK: begin
                car_cnt = car_cnt + 16'd1;
                if (car_cnt >= live_period()) car_cnt = 16'd0;
                if (playing) begin
                    if (pre_cnt >= shadow_cfg.tick_prescale) begin
                        pre_cnt = 8'd0;
                        if (units_left != 16'd0) units_left = units_left - 16'd1;
                        if (units_left == 16'd0) begin
                            if (gapping) begin
                                gapping = 1'b0;
                                load_slot(7'd0);
                            end else if (slot_ptr + 7'd1 < span) begin
                                load_slot(slot_ptr + 7'd1);
                            end else begin
                                gate      = 1'b0;
                                reps_left = reps_left - 16'd1;
                                slot_ptr  = 7'd0;
                                if (reps_left == 16'd0) begin
                                    playing    = 1'b0;
                                    units_left = 16'd0;
                                    ended      = 1'b1;
                                end else begin
                                    gapping    = 1'b1;
                                    units_left = (shadow_cfg.gap_duration == 16'd0) ? 16'd1
                                                 : shadow_cfg.gap_duration;
                                end
                            end
                        end
                    end else begin
                        pre_cnt = pre_cnt + 8'd1;
                    end
                end
            end
            default: ;
        endcase
        mark          = playing & gate;
        r.ir_out      = mark & (car_cnt < (live_period() >> 1));
        r.mark_active = mark;
        r.busy_res    = playing;
        r.done_res    = ended;
        return r;
    endfunction

    // result side: random or held-off ready
    always @(posedge aclk) begin
        if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            hold_left   <= HOLD_CYCLES;
            m_ready     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic expv, input logic actv);
        if (actv !== expv) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %b actual %b", $time, name, expv, actv);
        end
    endtask

    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_outputs.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result transfer, expected none actual %b%b%b%b",
                         $time, m_ir_out, m_mark_active, m_busy_res, m_done_res);
            end else begin
                want = awaited_outputs.pop_front();
                check_field("ir_out", want.ir_out, m_ir_out);
                check_field("mark_active", want.mark_active, m_mark_active);
                check_field("busy_res", want.busy_res, m_busy_res);
                check_field("done_res", want.done_res, m_done_res);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input logic [1:0] req, input logic [5:0] idx,
                                input logic [15:0] dur);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_req_type       <= req;
        s_entry_index    <= idx;
        s_entry_duration <= dur;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        awaited_outputs.push_back(predict_pulse_train(req, idx, dur));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (awaited_outputs.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic put_register(input logic [2:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_PATTERN_LENGTH: shadow_cfg.pattern_length = data[6:0];
            CFG_REPEAT_TOTAL:   shadow_cfg.repeat_total   = data;
            CFG_GAP_DURATION:   shadow_cfg.gap_duration   = data;
            CFG_CARRIER_PERIOD: shadow_cfg.carrier_period = data;
            CFG_TICK_PRESCALE:  shadow_cfg.tick_prescale  = data[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [6:0] len, input logic [15:0] reps,
                                  input logic [15:0] gap, input logic [15:0] period,
                                  input logic [7:0] prescale);
        wait_drained();
        put_register(CFG_PATTERN_LENGTH, {9'd0, len});
        put_register(CFG_REPEAT_TOTAL, reps);
        put_register(CFG_GAP_DURATION, gap);
        put_register(CFG_CARRIER_PERIOD, period);
        put_register(CFG_TICK_PRESCALE, {8'd0, prescale});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_duration();
        return ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(3));
    endfunction

    task automatic test_pattern_fill();
        for (int i = 0; i < IRPT_PATTERN_DEPTH; i++) begin
            send_request(REQ_WRITE, 6'(i), 16'($urandom_range(3)));
        end
    endtask

    // zero length, repeat, gap and a period below two
    task automatic test_single_mark();
        apply_settings(7'd0, 16'd0, 16'd0, 16'd0, 8'd0);
        send_request(REQ_WRITE, 6'd0, 16'd0);
        send_request(REQ_START, 6'd0, 16'd0);
        send_request(REQ_TICK, 6'd0, 16'd0);
        send_request(REQ_TICK, 6'd0, 16'd0);
        send_request(REQ_IGNORED, 6'd0, 16'd0);
    endtask

    task automatic test_restart_and_gap();
        apply_settings(7'd2, 16'd2, 16'd1, 16'hFFFF, 8'd0);
        send_request(REQ_WRITE, 6'd0, 16'd2);
        send_request(REQ_WRITE, 6'd1, 16'd1);
        send_request(REQ_START, 6'd0, 16'd0);
        send_request(REQ_TICK, 6'd0, 16'd0);
        send_request(REQ_WRITE, 6'd1, 16'd2);
        send_request(REQ_START, 6'd0, 16'd0);
        send_request(REQ_IGNORED, 6'h3F, 16'hFFFF);
        repeat (12) send_request(REQ_TICK, 6'h2A, 16'h5555);
    endtask

    task automatic test_register_extremes();
        apply_settings(7'h7F, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_request(REQ_WRITE, 6'h3F, 16'hFFFF);
        send_request(REQ_START, 6'h15, 16'hAAAA);
        send_request(REQ_TICK, 6'h3F, 16'hFFFF);
        send_request(REQ_TICK, 6'h3F, 16'hFFFF);
        send_request(REQ_WRITE, 6'h3F, 16'd2);
    endtask

    task automatic run_random_traffic(input int count);
        int         pick;
        logic [1:0] req;
        apply_settings(($urandom_range(4) == 0) ? 7'd64 : 7'($urandom_range(1, 6)),
                       16'($urandom_range(3)), 16'($urandom_range(3)),
                       16'($urandom_range(2, 12)), 8'($urandom_range(2)));
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 3) req = REQ_START;
            else if (pick < 13) req = REQ_WRITE;
            else if (pick < 16) req = REQ_IGNORED;
            else req = REQ_TICK;
            send_request(req, 6'($urandom_range(63)), pick_duration());
        end
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_output_backpressure();
        send_request(REQ_START, 6'($urandom_range(63)), 16'($urandom));
        hold_asked++;
        repeat (40) send_request(REQ_TICK, 6'($urandom_range(63)), 16'($urandom));
    endtask

    initial begin
        clear_prediction();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 37;
        recv_idle_pct = 52;
        test_pattern_fill();
        test_single_mark();
        test_restart_and_gap();
        test_register_extremes();
        run_random_traffic(110);
        send_idle_pct = 52;
        recv_idle_pct = 37;
        run_random_traffic(110);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_output_backpressure();
        run_random_traffic(90);
        wait_drained();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule
